// ===== design/date_offset_weekday_range_check_unit_macros.svh =====
// Assertion macros for the date offset / weekday / range check unit.
// Used by the top level; expects i_clk and i_rst_n in the enclosing module.
`ifndef DATE_OFFSET_WEEKDAY_RANGE_CHECK_UNIT_MACROS_SVH
`define DATE_OFFSET_WEEKDAY_RANGE_CHECK_UNIT_MACROS_SVH

// Same-cycle implication, off during reset
`define DOWRC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset
`define DOWRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/dowrc_pkg.sv =====
// Package for the date offset / weekday / range check unit.
// Field widths, calendar constants, stage types and helper functions; no dependencies.
`timescale 1ns / 1ps

package dowrc_pkg;

    // Field widths
    localparam int YEAR_W    = 14;
    localparam int MONTH_W   = 4;
    localparam int DAY_W     = 5;
    localparam int OFF_W     = 7;
    localparam int WDAY_W    = 3;
    localparam int DSUM_W    = 8;   // start day plus offset, signed
    localparam int SUM_W     = 15;  // weekday sum before mod 7
    localparam int TSUM_W    = 6;   // table entry plus day
    localparam int Q100_W    = 7;   // year / 100
    localparam int KEY_W     = YEAR_W + MONTH_W + DAY_W;

    // Pipeline depth
    localparam int NSTAGE    = 6;

    // Offset clamp
    localparam int MAX_OFFSET = 42;
    localparam logic signed [OFF_W-1:0] OFF_MAX = OFF_W'(MAX_OFFSET);
    localparam logic signed [OFF_W-1:0] OFF_MIN = OFF_W'(-MAX_OFFSET);

    // Calendar limits
    localparam logic [YEAR_W-1:0]  YEAR_LOW   = YEAR_W'(1);
    localparam logic [YEAR_W-1:0]  YEAR_HIGH  = YEAR_W'(9999);
    localparam logic [MONTH_W-1:0] MONTH_LOW  = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] MONTH_FEB  = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] MONTH_MAR  = MONTH_W'(3);
    localparam logic [MONTH_W-1:0] MONTH_HIGH = MONTH_W'(12);
    localparam logic [DAY_W-1:0]   DAY_LOW    = DAY_W'(1);
    localparam logic [DAY_W-1:0]   DAY_HIGH   = DAY_W'(31);
    localparam logic [YEAR_W-1:0]  CENTURY    = YEAR_W'(100);

    // Reciprocal for year / 100, exact for year < 10000
    localparam int DIV100_MUL_W = 13;
    localparam logic [DIV100_MUL_W-1:0] DIV100_MUL = DIV100_MUL_W'(5243);
    localparam int DIV100_SH    = 19;

    // Configuration port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_MIN_EN,
        REG_MIN_YEAR,
        REG_MIN_MONTH,
        REG_MIN_DAY,
        REG_MAX_EN,
        REG_MAX_YEAR,
        REG_MAX_MONTH,
        REG_MAX_DAY
    } t_reg_idx;

    // Date in flight through the carry/borrow steps
    typedef struct packed {
        logic [YEAR_W-1:0]        year;
        logic [MONTH_W-1:0]       month;
        logic signed [DSUM_W-1:0] day;
        logic                     leap;
        logic                     hi_sat;
        logic                     lo_sat;
    } t_step;

    // Days in a month; leap applies to February only
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] n;
        unique case (m)
            MONTH_W'(2):  n = leap ? DAY_W'(29) : DAY_W'(28);
            MONTH_W'(4),
            MONTH_W'(6),
            MONTH_W'(9),
            MONTH_W'(11): n = DAY_W'(30);
            default:      n = DAY_W'(31);
        endcase
        return n;
    endfunction

    // Month term of the weekday formula
    function automatic logic [WDAY_W-1:0] wd_month(input logic [MONTH_W-1:0] m);
        logic [WDAY_W-1:0] t;
        unique case (m)
            MONTH_W'(1):  t = WDAY_W'(0);
            MONTH_W'(2):  t = WDAY_W'(3);
            MONTH_W'(3):  t = WDAY_W'(2);
            MONTH_W'(4):  t = WDAY_W'(5);
            MONTH_W'(5):  t = WDAY_W'(0);
            MONTH_W'(6):  t = WDAY_W'(3);
            MONTH_W'(7):  t = WDAY_W'(5);
            MONTH_W'(8):  t = WDAY_W'(1);
            MONTH_W'(9):  t = WDAY_W'(4);
            MONTH_W'(10): t = WDAY_W'(6);
            MONTH_W'(11): t = WDAY_W'(2);
            MONTH_W'(12): t = WDAY_W'(4);
            default:      t = WDAY_W'(0);
        endcase
        return t;
    endfunction

    // year / 100 by reciprocal multiply
    function automatic logic [Q100_W-1:0] div100(input logic [YEAR_W-1:0] y);
        logic [YEAR_W+DIV100_MUL_W-1:0] p;
        p = (YEAR_W+DIV100_MUL_W)'(y) * (YEAR_W+DIV100_MUL_W)'(DIV100_MUL);
        return Q100_W'(p >> DIV100_SH);
    endfunction

    // x mod 7 by folding octal digits (8 = 1 mod 7)
    function automatic logic [WDAY_W-1:0] mod7(input logic [SUM_W-1:0] x);
        logic [5:0] a;
        logic [3:0] b;
        a = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9]) + 6'(x[14:12]);
        b = 4'(a[2:0]) + 4'(a[5:3]);
        return (b >= 4'd7) ? WDAY_W'(b - 4'd7) : WDAY_W'(b);
    endfunction

endpackage

// ===== design/dowrc_if.sv =====
// Valid/ready channel interfaces for the date offset / weekday / range check unit.
// Depends on dowrc_pkg for field widths.
`timescale 1ns / 1ps

// Input channel: starting date and day offset
interface dowrc_in_if;
    import dowrc_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [YEAR_W-1:0]         start_year;
    logic [MONTH_W-1:0]        start_month;
    logic [DAY_W-1:0]          start_day;
    logic signed [OFF_W-1:0]   day_offset;

    modport source (output valid, start_year, start_month, start_day, day_offset,
                    input ready);
    modport sink   (input valid, start_year, start_month, start_day, day_offset,
                    output ready);
endinterface

// Output channel: resulting date, weekday, enabled flag
interface dowrc_out_if;
    import dowrc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [YEAR_W-1:0]    result_year;
    logic [MONTH_W-1:0]   result_month;
    logic [DAY_W-1:0]     result_day;
    logic [WDAY_W-1:0]    weekday;
    logic                 enabled;

    modport source (output valid, result_year, result_month, result_day, weekday, enabled,
                    input ready);
    modport sink   (input valid, result_year, result_month, result_day, weekday, enabled,
                    output ready);
endinterface

// ===== design/date_offset_weekday_range_check_unit.sv =====
// Pipelined: one word per cycle while the output side keeps ready high; six register stages
// (clamp, two month steps, weekday terms, weekday sum, mod 7), each with its own valid bit
// and bubble-collapsing ready.
// Reset (i_rst_n low, synchronous) empties the pipeline and returns the limit
// registers to their reset values.
`timescale 1ns / 1ps
`include "date_offset_weekday_range_check_unit_macros.svh"

module date_offset_weekday_range_check_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    dowrc_in_if.sink                         i_date,
    dowrc_out_if.source                      o_result,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [dowrc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [dowrc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [dowrc_pkg::APB_DATA_W-1:0] prdata,
    output logic                             pready
);
    import dowrc_pkg::*;

    // limit registers
    logic                 r_min_en;
    logic [YEAR_W-1:0]    r_min_year;
    logic [MONTH_W-1:0]   r_min_month;
    logic [DAY_W-1:0]     r_min_day;
    logic                 r_max_en;
    logic [YEAR_W-1:0]    r_max_year;
    logic [MONTH_W-1:0]   r_max_month;
    logic [DAY_W-1:0]     r_max_day;
    t_reg_idx             w_idx;

    // pipeline control
    logic [NSTAGE-1:0]    r_vld;
    logic [NSTAGE:0]      w_rdy;
    logic [NSTAGE-1:0]    w_vin;

    // stage 1
    logic [YEAR_W-1:0]        w_y_clamp;
    logic [MONTH_W-1:0]       w_m_clamp;
    logic signed [OFF_W-1:0]  w_off_clamp;
    t_step                    n_s1;
    t_step                    r_s1;
    logic [Q100_W-1:0]        r_q1;
    // stage 2
    t_step                    w_s1l;
    t_step                    w_s2;
    t_step                    r_s2;
    // stage 3
    t_step                    w_s3;
    logic [YEAR_W-1:0]        n_y3;
    logic [MONTH_W-1:0]       n_m3;
    logic [DAY_W-1:0]         n_d3;
    logic [YEAR_W-1:0]        r_y3;
    logic [MONTH_W-1:0]       r_m3;
    logic [DAY_W-1:0]         r_d3;
    // stage 4
    logic [YEAR_W-1:0]        n_yy4;
    logic [KEY_W-1:0]         w_key;
    logic                     n_ok4;
    logic [YEAR_W-1:0]        r_y4;
    logic [MONTH_W-1:0]       r_m4;
    logic [DAY_W-1:0]         r_d4;
    logic [YEAR_W-1:0]        r_yy4;
    logic [Q100_W-1:0]        r_q4;
    logic [TSUM_W-1:0]        r_t4;
    logic                     r_ok4;
    // stage 5
    logic [SUM_W-1:0]         n_sum5;
    logic [YEAR_W-1:0]        r_y5;
    logic [MONTH_W-1:0]       r_m5;
    logic [DAY_W-1:0]         r_d5;
    logic [SUM_W-1:0]         r_sum5;
    logic                     r_ok5;
    // stage 6 (output register)
    logic [YEAR_W-1:0]        r_y6;
    logic [MONTH_W-1:0]       r_m6;
    logic [DAY_W-1:0]         r_d6;
    logic [WDAY_W-1:0]        r_wd6;
    logic                     r_ok6;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[APB_ADDR_W-1:2]);

    // register writes in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_en    <= 1'b0;
            r_min_year  <= YEAR_LOW;
            r_min_month <= MONTH_LOW;
            r_min_day   <= DAY_LOW;
            r_max_en    <= 1'b0;
            r_max_year  <= YEAR_HIGH;
            r_max_month <= MONTH_HIGH;
            r_max_day   <= DAY_HIGH;
        end else if (psel && penable && pwrite && pready) begin
            unique case (w_idx)
                REG_MIN_EN:    r_min_en    <= pwdata[0];
                REG_MIN_YEAR:  r_min_year  <= pwdata[YEAR_W-1:0];
                REG_MIN_MONTH: r_min_month <= pwdata[MONTH_W-1:0];
                REG_MIN_DAY:   r_min_day   <= pwdata[DAY_W-1:0];
                REG_MAX_EN:    r_max_en    <= pwdata[0];
                REG_MAX_YEAR:  r_max_year  <= pwdata[YEAR_W-1:0];
                REG_MAX_MONTH: r_max_month <= pwdata[MONTH_W-1:0];
                REG_MAX_DAY:   r_max_day   <= pwdata[DAY_W-1:0];
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (w_idx)
            REG_MIN_EN:    prdata = APB_DATA_W'(r_min_en);
            REG_MIN_YEAR:  prdata = APB_DATA_W'(r_min_year);
            REG_MIN_MONTH: prdata = APB_DATA_W'(r_min_month);
            REG_MIN_DAY:   prdata = APB_DATA_W'(r_min_day);
            REG_MAX_EN:    prdata = APB_DATA_W'(r_max_en);
            REG_MAX_YEAR:  prdata = APB_DATA_W'(r_max_year);
            REG_MAX_MONTH: prdata = APB_DATA_W'(r_max_month);
            REG_MAX_DAY:   prdata = APB_DATA_W'(r_max_day);
        endcase
    end

    // ---------------- pipeline control ----------------
    // a stage loads when it is empty or its word moves on
    always_comb begin
        w_rdy[NSTAGE] = o_result.ready;
        for (int k = NSTAGE - 1; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
        w_vin = {r_vld[NSTAGE-2:0], i_date.valid};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NSTAGE; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= w_vin[k];
                end
            end
        end
    end

    assign i_date.ready = w_rdy[0];

    // ---------------- stage 1: clamp inputs, add offset ----------------
    always_comb begin
        if (i_date.start_year < YEAR_LOW) begin
            w_y_clamp = YEAR_LOW;
        end else if (i_date.start_year > YEAR_HIGH) begin
            w_y_clamp = YEAR_HIGH;
        end else begin
            w_y_clamp = i_date.start_year;
        end

        if (i_date.start_month < MONTH_LOW) begin
            w_m_clamp = MONTH_LOW;
        end else if (i_date.start_month > MONTH_HIGH) begin
            w_m_clamp = MONTH_HIGH;
        end else begin
            w_m_clamp = i_date.start_month;
        end

        if (i_date.day_offset > OFF_MAX) begin
            w_off_clamp = OFF_MAX;
        end else if (i_date.day_offset < OFF_MIN) begin
            w_off_clamp = OFF_MIN;
        end else begin
            w_off_clamp = i_date.day_offset;
        end

        n_s1.year   = w_y_clamp;
        n_s1.month  = w_m_clamp;
        n_s1.day    = $signed(DSUM_W'(i_date.start_day)) + DSUM_W'(w_off_clamp);
        n_s1.leap   = 1'b0;
        n_s1.hi_sat = 1'b0;
        n_s1.lo_sat = 1'b0;
    end

    // ---------------- stage 2: leap year, first month step ----------------
    // only the start year's February length is ever needed, so one leap flag serves
    always_comb begin
        w_s1l      = r_s1;
        w_s1l.leap = (r_s1.year[1:0] == 2'b00)
                     && ((r_s1.year != YEAR_W'(r_q1) * CENTURY) || (r_q1[1:0] == 2'b00));
    end

    dowrc_month_step u_step1 (
        .i_cur (w_s1l),
        .o_nxt (w_s2)
    );

    // ---------------- stage 3: second month step, saturation ----------------
    dowrc_month_step u_step2 (
        .i_cur (r_s2),
        .o_nxt (w_s3)
    );

    always_comb begin
        priority if (w_s3.hi_sat) begin
            n_y3 = YEAR_HIGH;
            n_m3 = MONTH_HIGH;
            n_d3 = DAY_HIGH;
        end else if (w_s3.lo_sat) begin
            n_y3 = YEAR_LOW;
            n_m3 = MONTH_LOW;
            n_d3 = DAY_LOW;
        end else begin
            n_y3 = w_s3.year;
            n_m3 = w_s3.month;
            n_d3 = w_s3.day[DAY_W-1:0];
        end
    end

    // ---------------- stage 4: weekday terms, limit compare ----------------
    // January and February count with the previous year
    assign n_yy4 = (r_m3 < MONTH_MAR) ? r_y3 - YEAR_W'(1) : r_y3;
    assign w_key = {r_y3, r_m3, r_d3};
    assign n_ok4 = !(r_min_en && (w_key < {r_min_year, r_min_month, r_min_day}))
                   && !(r_max_en && (w_key > {r_max_year, r_max_month, r_max_day}));

    // ---------------- stage 5: weekday sum ----------------
    assign n_sum5 = SUM_W'(r_yy4) + SUM_W'(r_yy4 >> 2) + SUM_W'(r_q4 >> 2)
                  + SUM_W'(r_t4) - SUM_W'(r_q4);

    // ---------------- stage payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_s1 <= n_s1;
            r_q1 <= div100(w_y_clamp);
        end
        if (w_rdy[1]) begin
            r_s2 <= w_s2;
        end
        if (w_rdy[2]) begin
            r_y3 <= n_y3;
            r_m3 <= n_m3;
            r_d3 <= n_d3;
        end
        if (w_rdy[3]) begin
            r_y4  <= r_y3;
            r_m4  <= r_m3;
            r_d4  <= r_d3;
            r_yy4 <= n_yy4;
            r_q4  <= div100(n_yy4);
            r_t4  <= TSUM_W'(wd_month(r_m3)) + TSUM_W'(r_d3);
            r_ok4 <= n_ok4;
        end
        if (w_rdy[4]) begin
            r_y5   <= r_y4;
            r_m5   <= r_m4;
            r_d5   <= r_d4;
            r_sum5 <= n_sum5;
            r_ok5  <= r_ok4;
        end
        if (w_rdy[5]) begin
            r_y6  <= r_y5;
            r_m6  <= r_m5;
            r_d6  <= r_d5;
            r_wd6 <= mod7(r_sum5);
            r_ok6 <= r_ok5;
        end
    end

    // ---------------- output word ----------------
    assign o_result.valid        = r_vld[NSTAGE-1];
    assign o_result.result_year  = r_y6;
    assign o_result.result_month = r_m6;
    assign o_result.result_day   = r_d6;
    assign o_result.weekday      = r_wd6;
    assign o_result.enabled      = r_ok6;

    // ---------------- assertions ----------------
    `DOWRC_ASSERT_NOW(a_result_in_range, o_result.valid, (o_result.result_year >= YEAR_LOW) && (o_result.result_year <= YEAR_HIGH) && (o_result.result_month >= MONTH_LOW) && (o_result.result_month <= MONTH_HIGH) && (o_result.result_day >= DAY_LOW) && (o_result.weekday <= WDAY_W'(6)), "result word outside calendar range")
    `DOWRC_ASSERT_NEXT(a_accept_loads, i_date.valid && i_date.ready, r_vld[0], "accepted word did not enter stage 1")
    `DOWRC_ASSERT_NEXT(a_stage3_holds, r_vld[2] && !w_rdy[3], r_vld[2] && $stable(r_y3) && $stable(r_m3) && $stable(r_d3), "stalled stage 3 word lost or changed")

endmodule

// ===== design/dowrc_month_step.sv =====
// One month carry or borrow step on a date whose day may be out of range.
// Depends on dowrc_pkg (t_step, month_len, calendar limits).
`timescale 1ns / 1ps

module dowrc_month_step (
    input  dowrc_pkg::t_step i_cur,
    output dowrc_pkg::t_step o_nxt
);
    import dowrc_pkg::*;

    logic [DAY_W-1:0]   w_cur_len;
    logic [DAY_W-1:0]   w_prev_len;
    logic [MONTH_W-1:0] w_prev_m;

    // lengths of this month and of the month before
    assign w_prev_m   = (i_cur.month == MONTH_LOW) ? MONTH_HIGH : i_cur.month - MONTH_W'(1);
    assign w_cur_len  = month_len(i_cur.month, i_cur.leap);
    assign w_prev_len = month_len(w_prev_m, i_cur.leap);

    // carry forward if past month end, borrow back if before day one
    always_comb begin
        o_nxt = i_cur;
        if (!i_cur.hi_sat && !i_cur.lo_sat) begin
            if (i_cur.day > $signed(DSUM_W'(w_cur_len))) begin
                o_nxt.day = i_cur.day - $signed(DSUM_W'(w_cur_len));
                if (i_cur.month == MONTH_HIGH) begin
                    o_nxt.month = MONTH_LOW;
                    if (i_cur.year == YEAR_HIGH) begin
                        o_nxt.hi_sat = 1'b1;
                    end else begin
                        o_nxt.year = i_cur.year + YEAR_W'(1);
                    end
                end else begin
                    o_nxt.month = i_cur.month + MONTH_W'(1);
                end
            end else if (i_cur.day < $signed(DSUM_W'(DAY_LOW))) begin
                o_nxt.month = w_prev_m;
                if (i_cur.month == MONTH_LOW && i_cur.year == YEAR_LOW) begin
                    o_nxt.lo_sat = 1'b1;
                end else begin
                    if (i_cur.month == MONTH_LOW) begin
                        o_nxt.year = i_cur.year - YEAR_W'(1);
                    end
                    o_nxt.day = i_cur.day + $signed(DSUM_W'(w_prev_len));
                end
            end
        end
    end

endmodule

// ===== test/dowrc_date_checker.sv =====
// Checker for the date offset / weekday / range check unit: watches both word channels
// and the APB port, predicts each result word and compares it field by field.
// Depends on dowrc_pkg and the channel interfaces in dowrc_if.sv.
`timescale 1ns / 1ps

module dowrc_date_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    dowrc_in_if                              date_ch,
    dowrc_out_if                             result_ch,
    input  logic                             i_psel,
    input  logic                             i_penable,
    input  logic                             i_pwrite,
    input  logic [dowrc_pkg::APB_ADDR_W-1:0] i_paddr,
    input  logic [dowrc_pkg::APB_DATA_W-1:0] i_pwdata,
    input  logic [dowrc_pkg::APB_DATA_W-1:0] i_prdata,
    input  logic                             i_pready,
    output int                               o_mismatch_count,
    output int                               o_due_count
);
    import dowrc_pkg::*;

    // Month term of the weekday sum, January first
    localparam int WD_TERM [12] = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [WDAY_W-1:0]  weekday;
        logic               enabled;
    } t_shifted_date;

    // Local copy of the limit registers
    logic               lim_min_en;
    logic [YEAR_W-1:0]  lim_min_year;
    logic [MONTH_W-1:0] lim_min_month;
    logic [DAY_W-1:0]   lim_min_day;
    logic               lim_max_en;
    logic [YEAR_W-1:0]  lim_max_year;
    logic [MONTH_W-1:0] lim_max_month;
    logic [DAY_W-1:0]   lim_max_day;

    t_shifted_date due_results [$];
    int            mismatches = 0;

    assign o_mismatch_count = mismatches;

    function automatic int month_days(input int y, input int m);
        int n;
        case (m)
            2:             n = ((y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0))) ? 29 : 28;
            4, 6, 9, 11:   n = 30;
            default:       n = 31;
        endcase
        return n;
    endfunction

    // Expected result word for one date word under the current limits
    function automatic t_shifted_date shift_date(input logic [YEAR_W-1:0] sy,
                                                 input logic [MONTH_W-1:0] sm,
                                                 input logic [DAY_W-1:0] sd,
                                                 input logic signed [OFF_W-1:0] soff);
        int            y, m, d, off, yy;
        bit            hi_sat, lo_sat;
        logic [KEY_W-1:0] key;
        t_shifted_date r;
        y = sy;
        m = sm;
        off = soff;
        hi_sat = 1'b0;
        lo_sat = 1'b0;
        if (off > MAX_OFFSET) off = MAX_OFFSET;
        if (off < -MAX_OFFSET) off = -MAX_OFFSET;
        if (y < 1) y = 1;
        if (y > 9999) y = 9999;
        if (m < 1) m = 1;
        if (m > 12) m = 12;
        d = int'(sd) + off;
        // carry forward a month at a time
        while (!hi_sat && d > month_days(y, m)) begin
            d -= month_days(y, m);
            m++;
            if (m > 12) begin
                m = 1;
                if (y == 9999) hi_sat = 1'b1;
                else y++;
            end
        end
        // borrow backward; day 0 lands on the last day of the month before
        while (!lo_sat && d < 1) begin
            m--;
            if (m < 1) begin
                m = 12;
                if (y == 1) lo_sat = 1'b1;
                else y--;
            end
            if (!lo_sat) d += month_days(y, m);
        end
        if (hi_sat) begin
            y = 9999; m = 12; d = 31;
        end
        if (lo_sat) begin
            y = 1; m = 1; d = 1;
        end
        yy = (m < 3) ? y - 1 : y;
        r.year    = YEAR_W'(y);
        r.month   = MONTH_W'(m);
        r.day     = DAY_W'(d);
        r.weekday = WDAY_W'((yy + yy / 4 - yy / 100 + yy / 400 + WD_TERM[m-1] + d) % 7);
        key = {r.year, r.month, r.day};
        r.enabled = 1'b1;
        if (lim_min_en && key < {lim_min_year, lim_min_month, lim_min_day}) r.enabled = 1'b0;
        if (lim_max_en && key > {lim_max_year, lim_max_month, lim_max_day}) r.enabled = 1'b0;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Track register writes, check reads, queue predictions, match result words
    always @(posedge i_clk) begin : watch_channels
        t_shifted_date    want;
        logic [31:0]      reg_val;
        t_reg_idx         idx;
        idx = t_reg_idx'(i_paddr[REG_IDX_W+1:2]);
        if (!i_rst_n) begin
            lim_min_en    = 1'b0;
            lim_min_year  = YEAR_W'(1);
            lim_min_month = MONTH_W'(1);
            lim_min_day   = DAY_W'(1);
            lim_max_en    = 1'b0;
            lim_max_year  = YEAR_W'(9999);
            lim_max_month = MONTH_W'(12);
            lim_max_day   = DAY_W'(31);
            due_results.delete();
        end else begin
            if (i_psel && i_penable && i_pready && i_pwrite) begin
                case (idx)
                    REG_MIN_EN:    lim_min_en    = i_pwdata[0];
                    REG_MIN_YEAR:  lim_min_year  = i_pwdata[YEAR_W-1:0];
                    REG_MIN_MONTH: lim_min_month = i_pwdata[MONTH_W-1:0];
                    REG_MIN_DAY:   lim_min_day   = i_pwdata[DAY_W-1:0];
                    REG_MAX_EN:    lim_max_en    = i_pwdata[0];
                    REG_MAX_YEAR:  lim_max_year  = i_pwdata[YEAR_W-1:0];
                    REG_MAX_MONTH: lim_max_month = i_pwdata[MONTH_W-1:0];
                    REG_MAX_DAY:   lim_max_day   = i_pwdata[DAY_W-1:0];
                    default: ;
                endcase
            end
            if (i_psel && i_penable && i_pready && !i_pwrite) begin
                case (idx)
                    REG_MIN_EN:    reg_val = 32'(lim_min_en);
                    REG_MIN_YEAR:  reg_val = 32'(lim_min_year);
                    REG_MIN_MONTH: reg_val = 32'(lim_min_month);
                    REG_MIN_DAY:   reg_val = 32'(lim_min_day);
                    REG_MAX_EN:    reg_val = 32'(lim_max_en);
                    REG_MAX_YEAR:  reg_val = 32'(lim_max_year);
                    REG_MAX_MONTH: reg_val = 32'(lim_max_month);
                    default:       reg_val = 32'(lim_max_day);
                endcase
                check_field("prdata", reg_val, i_prdata);
            end
            if (date_ch.valid && date_ch.ready)
                due_results.push_back(shift_date(date_ch.start_year, date_ch.start_month,
                                                 date_ch.start_day, date_ch.day_offset));
            if (result_ch.valid && result_ch.ready) begin
                if (due_results.size() == 0) begin
                    $error("result word arrived with no date word outstanding");
                    mismatches++;
                end else begin
                    want = due_results.pop_front();
                    check_field("result_year", 32'(want.year), 32'(result_ch.result_year));
                    check_field("result_month", 32'(want.month), 32'(result_ch.result_month));
                    check_field("result_day", 32'(want.day), 32'(result_ch.result_day));
                    check_field("weekday", 32'(want.weekday), 32'(result_ch.weekday));
                    check_field("enabled", 32'(want.enabled), 32'(result_ch.enabled));
                end
            end
        end
        o_due_count = due_results.size();
    end

endmodule

// ===== test/tb_date_offset_weekday_range_check_unit.sv =====
// Testbench top for the date offset / weekday / range check unit: clock, reset,
// date word and APB stimulus, random result back-pressure, watchdog and verdict.
// Depends on dowrc_pkg, dowrc_if.sv, the unit itself and dowrc_date_checker.
`timescale 1ns / 1ps

module tb_date_offset_weekday_range_check_unit;
    import dowrc_pkg::*;

    localparam int NUM_PHASES      = 9;
    localparam int ITEMS_PER_PHASE = 208;
    localparam int LONG_HOLD       = 300;
    localparam int WATCHDOG_LIMIT  = 2000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int mismatch_count;
    int due_count;
    int sent = 0;
    int long_holds = 0;
    int idle_cycles = 0;

    dowrc_in_if  date_ch ();
    dowrc_out_if result_ch ();

    date_offset_weekday_range_check_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_date   (date_ch),
        .o_result (result_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    dowrc_date_checker date_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .date_ch          (date_ch),
        .result_ch        (result_ch),
        .i_psel           (psel),
        .i_penable        (penable),
        .i_pwrite         (pwrite),
        .i_paddr          (paddr),
        .i_pwdata         (pwdata),
        .i_prdata         (prdata),
        .i_pready         (pready),
        .o_mismatch_count (mismatch_count),
        .o_due_count      (due_count)
    );

    always #5 i_clk = ~i_clk;

    // Mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(99);
        if (r < 70) return 1 + $urandom_range(2);
        if (r < 95) return 4 + $urandom_range(6);
        return 20 + $urandom_range(40);
    endfunction

    function automatic int month_days(input int y, input int m);
        if (m == 2) return ((y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0))) ? 29 : 28;
        if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
        return 31;
    endfunction

    // One APB transfer: setup cycle, then access cycle
    task automatic apb_access(input logic wr, input t_reg_idx idx,
                              input logic [APB_DATA_W-1:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= APB_ADDR_W'(idx) << 2;
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Offer one date word and hold it until accepted; entered and left at a falling edge
    bit tx_steady = 1'b0;
    task automatic send_date(input int y, input int m, input int d, input int off);
        int gap;
        if (sent % 100 == 0) tx_steady = ($urandom_range(99) < 30);
        gap = (tx_steady || $urandom_range(1) == 0) ? 0 : idle_len();
        if (gap > 0) begin
            date_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        date_ch.valid       <= 1'b1;
        date_ch.start_year  <= YEAR_W'(y);
        date_ch.start_month <= MONTH_W'(m);
        date_ch.start_day   <= DAY_W'(d);
        date_ch.day_offset  <= OFF_W'(off);
        do @(posedge i_clk); while (!date_ch.ready);
        @(negedge i_clk);
        sent++;
    endtask

    // Mostly valid dates around a focus month and the calendar ends, some raw noise
    task automatic send_random(input int fy, input int fm);
        int r, y, m, d, off, len;
        r = $urandom_range(99);
        if (r < 12) begin
            y   = $urandom_range(16383);
            m   = $urandom_range(15);
            d   = $urandom_range(31);
            off = int'($urandom_range(127)) - 64;
        end else begin
            r = $urandom_range(99);
            m = 1 + $urandom_range(11);
            if (r < 45) begin
                y = fy;
                m = fm + int'($urandom_range(2)) - 1;
                if (m < 1) begin
                    m = 12; y--;
                end
                if (m > 12) begin
                    m = 1; y++;
                end
            end else if (r < 55) y = 1 + $urandom_range(2);
            else if (r < 65) y = 9997 + $urandom_range(2);
            else if (r < 75) y = 100 * (1 + $urandom_range(99));
            else y = 1 + $urandom_range(9998);
            if (y < 1) y = 1;
            if (y > 9999) y = 9999;
            len = month_days(y, m);
            r = $urandom_range(99);
            if (r < 30) d = len - $urandom_range(2);
            else if (r < 45) d = 1 + $urandom_range(2);
            else d = 1 + $urandom_range(len - 1);
            if ($urandom_range(99) < 25)
                off = ($urandom_range(1) == 1) ? 42 - int'($urandom_range(3))
                                               : -42 + int'($urandom_range(3));
            else
                off = int'($urandom_range(84)) - 42;
        end
        send_date(y, m, d, off);
    endtask

    // Stop offering and wait until every expected result word is back
    task automatic wait_drained();
        date_ch.valid <= 1'b0;
        while (due_count != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // Result side: random ready, plus a long hold-off every so many words sent
    initial begin : result_sink
        int hold_left;
        int rx_cycles;
        int next_hold_at;
        bit rx_steady;
        hold_left    = 0;
        rx_cycles    = 0;
        next_hold_at = 300;
        rx_steady    = 1'b0;
        result_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            rx_cycles++;
            if (rx_cycles % 500 == 0) rx_steady = ($urandom_range(99) < 30);
            if (hold_left == 0) begin
                if (sent >= next_hold_at) begin
                    hold_left = LONG_HOLD;
                    next_hold_at += 700;
                    long_holds++;
                end else if (!rx_steady && $urandom_range(99) < 35) begin
                    hold_left = idle_len();
                end
            end
            if (hold_left > 0) begin
                result_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any accepted word or APB transfer
    always @(posedge i_clk) begin
        if ((date_ch.valid && date_ch.ready) || (result_ch.valid && result_ch.ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no traffic for %0d cycles, %0d results outstanding",
                     idle_cycles, due_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // Stimulus: limit settings in phases, directed words first, then random words
    initial begin : stimulus
        logic [APB_DATA_W-1:0] limit_vals [8];
        int fy, fm;
        date_ch.valid       = 1'b0;
        date_ch.start_year  = '0;
        date_ch.start_month = '0;
        date_ch.start_day   = '0;
        date_ch.day_offset  = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            fy = 2000;
            fm = 2;
            case (ph)
                1: begin   // one-month window
                    limit_vals = '{1, 2000, 3, 1, 1, 2000, 3, 31};
                    fm = 3;
                end
                2: begin   // writes with high bits set, masked: everything enabled
                    limit_vals = '{32'hFFFF_FFFF, 32'hFFFF_C000, 32'hFFFF_FFF0, 32'hFFFF_FFE0,
                                   32'h8000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
                    fy = 5000;
                    fm = 6;
                end
                3: begin   // minimum above any date
                    limit_vals = '{1, 16383, 15, 31, 0, 1, 1, 1};
                    fy = 9999;
                    fm = 12;
                end
                4: begin   // only the first day of year one passes
                    limit_vals = '{0, 9999, 12, 31, 1, 1, 1, 1};
                    fy = 1;
                    fm = 1;
                end
                5: begin   // last month of the calendar
                    limit_vals = '{1, 9999, 12, 1, 1, 9999, 12, 31};
                    fy = 9999;
                    fm = 12;
                end
                6: begin   // window across a year boundary
                    limit_vals = '{1, 1999, 12, 25, 1, 2000, 1, 10};
                    fm = 1;
                end
                7: begin   // random window, month and day may be out of range
                    fy = 1 + $urandom_range(9998);
                    fm = 1 + $urandom_range(11);
                    limit_vals = '{32'($urandom_range(1)), 32'(fy), 32'(fm),
                                   32'(1 + $urandom_range(30)), 32'($urandom_range(1)),
                                   32'(fy + $urandom_range(1)),
                                   32'(($urandom_range(3) == 0) ? $urandom_range(15) : fm),
                                   32'($urandom_range(31))};
                end
                8: begin   // back to the reset values
                    limit_vals = '{0, 1, 1, 1, 0, 9999, 12, 31};
                    fy = 1900;
                end
                default: ;
            endcase
            if (ph != 0)
                for (int i = 0; i < 8; i++) apb_access(1'b1, t_reg_idx'(i), limit_vals[i]);
            for (int i = 0; i < 8; i++) apb_access(1'b0, t_reg_idx'(i), '0);

            if (ph == 0) begin
                // calendar ends and saturation
                send_date(1, 1, 1, -1);
                send_date(1, 1, 1, 0);
                send_date(1, 2, 10, -42);
                send_date(1, 1, 31, -31);
                send_date(9999, 12, 31, 1);
                send_date(9999, 12, 31, 0);
                send_date(9999, 11, 25, 42);
                // fields out of range, offset clamp
                send_date(0, 0, 0, 0);
                send_date(1, 0, 0, -42);
                send_date(16383, 15, 31, 63);
                send_date(10000, 1, 1, -42);
                send_date(2023, 13, 5, 30);
                send_date(2023, 6, 15, -64);
                send_date(2023, 5, 5, 43);
                // leap rules and month/year crossings
                send_date(2000, 2, 28, 1);
                send_date(1900, 2, 28, 1);
                send_date(2024, 3, 1, -1);
                send_date(2023, 12, 31, 1);
                send_date(2024, 1, 1, -1);
                send_date(2023, 1, 10, -42);
                send_date(2023, 1, 31, 42);
                send_date(2024, 1, 20, 42);
                // day not valid for its month, then a plain valid date
                send_date(2023, 3, 0, 0);
                send_date(2023, 4, 31, 0);
                send_date(2023, 7, 4, 0);
            end

            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                send_random(fy, fm);
                // sender pause mid-phase until the pipeline is empty
                if (ph == 3 && k == ITEMS_PER_PHASE / 2) wait_drained();
            end
            wait_drained();
        end

        $display("Sent %0d date words over %0d limit settings with %0d long result hold-offs;",
                 sent, NUM_PHASES, long_holds);
        $display("covered both calendar ends, leap days, out-of-range fields and limit edges.");
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
